// ----- src/tccc_pkg.sv -----
// Shared types, codes and reset values of the text console cursor controller.
package tccc_pkg;

  // Command codes sent to the drawing side.
  typedef enum logic [1:0] {
    CMD_PUT     = 2'd0,
    CMD_ROLL    = 2'd1,
    CMD_REFRESH = 2'd2,
    CMD_CLEAR   = 2'd3
  } command_e;

  // Input operations.
  typedef enum logic {
    OP_WRITE    = 1'b0,
    OP_BASELINE = 1'b1
  } operation_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LINE_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_WINDOW_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BUFFER_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_TEXT_ATTR     = 2'd3;

  // Register values after reset.
  localparam logic [7:0] LINE_WIDTH_RST    = 8'd80;
  localparam logic [8:0] WINDOW_HEIGHT_RST = 9'd25;
  localparam logic [8:0] BUFFER_HEIGHT_RST = 9'd100;
  localparam logic [7:0] TEXT_ATTR_RST     = 8'h0F;

  // Control characters.
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_VT  = 8'd11;
  localparam logic [7:0] CH_FF  = 8'd12;
  localparam logic [7:0] CH_CR  = 8'd13;

  // Tab stops fall on multiples of this power of two.
  localparam int TAB_STEP = 4;

  // Most commands one input beat can cause.
  localparam int RESULTS_MAX = 3;

  typedef logic [1:0] res_cnt_t;

  typedef struct packed {
    logic [7:0] line_width;
    logic [8:0] window_height;
    logic [8:0] buffer_height;
    logic [7:0] text_attribute;
  } cfg_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_code;
    logic [8:0] requested_baseline;
  } item_t;

  typedef struct packed {
    command_e   command;
    logic [6:0] column;
    logic [7:0] row;
    logic [7:0] out_char;
    logic [7:0] out_attribute;
    logic [7:0] view_baseline;
    logic       last;
  } result_t;

endpackage

// ----- src/tccc_step.sv -----
// Single-pass cursor, view and command logic for one input beat.
module tccc_step #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_LINES   = 256
) (
  input  tccc_pkg::cfg_t                         cfg_i,
  input  tccc_pkg::item_t                        item_i,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]       col_i,
  input  logic [$clog2(MAX_LINES)-1:0]           row_i,
  input  logic [7:0]                             base_i,
  output logic [$clog2(MAX_COLUMNS+1)-1:0]       next_col_o,
  output logic [$clog2(MAX_LINES)-1:0]           next_row_o,
  output logic [7:0]                             next_base_o,
  output tccc_pkg::result_t                      res_o [tccc_pkg::RESULTS_MAX],
  output tccc_pkg::res_cnt_t                     res_cnt_o
);
  import tccc_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int RW = $clog2(MAX_LINES);
  localparam int BW = $clog2(MAX_LINES + 1);
  localparam int XW = ((BW > 8) ? BW : 8) + 1;
  localparam int TW = $clog2(TAB_STEP);

  logic [CW-1:0] width;
  logic [XW-1:0] buf_h, win_h, top, row_x, base_x, y_x;
  logic [7:0]    y;
  logic [CW:0]   tab_col;

  logic          lf_roll;
  logic [RW-1:0] lf_row;
  logic [7:0]    lf_base;
  result_t       lf_res [2];
  res_cnt_t      lf_n;
  res_cnt_t      res_n;

  function automatic result_t mk(command_e cmd, logic [6:0] col, logic [7:0] row,
                                 logic [7:0] ch, logic [7:0] attr, logic [7:0] base);
    result_t r;
    r.command       = cmd;
    r.column        = col;
    r.row           = row;
    r.out_char      = ch;
    r.out_attribute = attr;
    r.view_baseline = base;
    r.last          = 1'b0;
    return r;
  endfunction

  // Effective sizes, saturated into their legal ranges.
  always_comb begin
    if (cfg_i.line_width == '0) begin
      width = CW'(1);
    end else if (9'(cfg_i.line_width) > 9'(MAX_COLUMNS)) begin
      width = CW'(MAX_COLUMNS);
    end else begin
      width = CW'(cfg_i.line_width);
    end

    if (cfg_i.buffer_height == '0) begin
      buf_h = XW'(1);
    end else if (XW'(cfg_i.buffer_height) > XW'(MAX_LINES)) begin
      buf_h = XW'(MAX_LINES);
    end else begin
      buf_h = XW'(cfg_i.buffer_height);
    end

    if (cfg_i.window_height == '0) begin
      win_h = XW'(1);
    end else if (XW'(cfg_i.window_height) > buf_h) begin
      win_h = buf_h;
    end else begin
      win_h = XW'(cfg_i.window_height);
    end
  end

  assign top    = buf_h - win_h;
  assign row_x  = XW'(row_i);
  assign base_x = XW'(base_i);

  // Line feed: step down a row, or roll the buffer on the bottom row.
  always_comb begin
    lf_roll = 1'b0;
    lf_row  = row_i;
    lf_base = base_i;
    if (row_x < buf_h - XW'(1)) begin
      lf_row = row_i + RW'(1);
      if (XW'(lf_row) == base_x + win_h) begin
        lf_base = base_i + 8'd1;
      end
    end else begin
      lf_roll = 1'b1;
      if (base_x < top && base_i != '0) begin
        lf_base = base_i - 8'd1;
      end
    end

    if (lf_roll) begin
      lf_res[0] = mk(CMD_ROLL, '0, '0, '0, '0, base_i);
      lf_res[1] = mk(CMD_REFRESH, '0, '0, '0, '0, lf_base);
      lf_n      = 2'd2;
    end else begin
      lf_res[0] = mk(CMD_REFRESH, '0, '0, '0, '0, lf_base);
      lf_res[1] = mk(CMD_REFRESH, '0, '0, '0, '0, lf_base);
      lf_n      = 2'd1;
    end
  end

  // Requested view baseline, clamped to the cursor row and the top limit.
  always_comb begin
    y_x = XW'(item_i.requested_baseline[7:0]);
    if (y_x > row_x) begin
      y_x = row_x;
    end
    if (y_x >= top) begin
      y_x = top;
    end
    y = item_i.requested_baseline[8] ? 8'd0 : 8'(y_x);
  end

  // Next tab stop, saturated at the line width.
  always_comb begin
    tab_col = {1'b0, col_i[CW-1:TW], TW'(0)} + (CW+1)'(TAB_STEP);
    if (tab_col > {1'b0, width}) begin
      tab_col = {1'b0, width};
    end
  end

  always_comb begin
    next_col_o  = col_i;
    next_row_o  = row_i;
    next_base_o = base_i;
    res_o       = '{default: '0};
    res_n       = '0;

    if (operation_e'(item_i.operation) == OP_BASELINE) begin
      next_base_o = y;
      res_o[0]    = mk(CMD_REFRESH, '0, '0, '0, '0, y);
      res_n       = 2'd1;
    end else begin
      case (item_i.char_code)
        CH_CR: begin
          next_col_o = '0;
        end
        CH_LF: begin
          next_row_o  = lf_row;
          next_base_o = lf_base;
          res_o[0]    = lf_res[0];
          res_o[1]    = lf_res[1];
          res_n       = lf_n;
        end
        CH_VT: begin
          if (col_i != '0) begin
            next_col_o  = '0;
            next_row_o  = lf_row;
            next_base_o = lf_base;
            res_o[0]    = lf_res[0];
            res_o[1]    = lf_res[1];
            res_n       = lf_n;
          end
        end
        CH_BS: begin
          if (col_i != '0) begin
            next_col_o = col_i - CW'(1);
          end else if (row_i != '0) begin
            next_row_o = row_i - RW'(1);
            next_col_o = width - CW'(1);
          end
        end
        CH_FF: begin
          next_col_o  = '0;
          next_row_o  = '0;
          next_base_o = '0;
          res_o[0]    = mk(CMD_CLEAR, '0, '0, '0, '0, base_i);
          res_o[1]    = mk(CMD_REFRESH, '0, '0, '0, '0, 8'd0);
          res_n       = 2'd2;
        end
        CH_TAB: begin
          next_col_o = CW'(tab_col);
        end
        default: begin
          if (col_i >= width) begin
            // Wrap to a fresh line before the character goes down.
            next_row_o   = lf_row;
            next_base_o  = lf_base;
            next_col_o   = CW'(1);
            res_o[0]     = lf_res[0];
            res_o[1]     = lf_res[1];
            res_o[lf_n]  = mk(CMD_PUT, 7'd0, 8'(lf_row), item_i.char_code,
                              cfg_i.text_attribute, lf_base);
            res_n        = lf_n + 2'd1;
          end else begin
            next_col_o = col_i + CW'(1);
            res_o[0]   = mk(CMD_PUT, 7'(col_i), 8'(row_i), item_i.char_code,
                            cfg_i.text_attribute, base_i);
            res_n      = 2'd1;
          end
        end
      endcase
    end

    if (res_n != '0) begin
      res_o[res_n - 2'd1].last = 1'b1;
    end
  end

  assign res_cnt_o = res_n;

endmodule

// ----- src/text_console_cursor_control_unit.sv -----
// Top level of the text console cursor and scrollback controller.
//
// The controller keeps the cursor (column and buffer row) and the first buffer line shown in the
// view window, and turns each input beat into zero to three command beats for the drawing side:
// put a character, roll the buffer up one line, refresh the view, or clear the buffer. An input
// beat is first captured in an input register; the cursor logic then runs in one pass and loads
// its commands into a three-entry result queue that presents one command beat per cycle while
// out_ready_i is high; input beats that cause no command or one command then stream at one per
// cycle. A beat that causes no command passes straight through even while a finished command
// waits for out_ready_i; a beat that causes commands waits in the input register until the queue
// is empty or is handing over its final entry. A beat that causes more than one command therefore
// holds the input side while the result queue drains, so the rate is set by the queue's single
// output port. Configuration registers are written through the plain write port and take effect
// for the next input beat; they should be written only while the block is idle.

module text_console_cursor_control_unit #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_LINES   = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i,

  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       operation_i,
  input  logic [7:0] char_code_i,
  input  logic signed [8:0] requested_baseline_i,

  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] command_o,
  output logic [6:0] column_o,
  output logic [7:0] row_o,
  output logic [7:0] out_char_o,
  output logic [7:0] out_attribute_o,
  output logic [7:0] view_baseline_o,
  output logic       last_o
);
  import tccc_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W = $clog2(MAX_LINES);

  // Configuration registers.
  cfg_t cfg_q;

  // Input register.
  logic  item_valid_q;
  item_t item_q;

  // Cursor and view state.
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [7:0]       base_q, base_d;

  // Result queue; entry 0 is the one presented on the output.
  result_t  res_q [RESULTS_MAX];
  res_cnt_t cnt_q;

  result_t  step_res [RESULTS_MAX];
  res_cnt_t step_cnt;

  logic pop, room, fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width     <= LINE_WIDTH_RST;
      cfg_q.window_height  <= WINDOW_HEIGHT_RST;
      cfg_q.buffer_height  <= BUFFER_HEIGHT_RST;
      cfg_q.text_attribute <= TEXT_ATTR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LINE_WIDTH:    cfg_q.line_width     <= cfg_data_i[7:0];
        CFG_WINDOW_HEIGHT: cfg_q.window_height  <= cfg_data_i;
        CFG_BUFFER_HEIGHT: cfg_q.buffer_height  <= cfg_data_i;
        CFG_TEXT_ATTR:     cfg_q.text_attribute <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // The queue takes a new set of commands when it is empty or is handing over its final entry in
  // this cycle. A beat that causes no command never needs the queue and passes straight through.
  assign pop  = out_valid_o && out_ready_i;
  assign room = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
  assign fire = item_valid_q && (room || step_cnt == 2'd0);

  assign in_ready_o = !item_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.operation          <= operation_i;
      item_q.char_code          <= char_code_i;
      item_q.requested_baseline <= requested_baseline_i;
    end
  end

  tccc_step #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_LINES   (MAX_LINES)
  ) u_step (
    .cfg_i       (cfg_q),
    .item_i      (item_q),
    .col_i       (col_q),
    .row_i       (row_q),
    .base_i      (base_q),
    .next_col_o  (col_d),
    .next_row_o  (row_d),
    .next_base_o (base_d),
    .res_o       (step_res),
    .res_cnt_o   (step_cnt)
  );

  // The cursor and view only move when the input register hands its beat on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      base_q <= '0;
    end else if (fire) begin
      col_q  <= col_d;
      row_q  <= row_d;
      base_q <= base_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (fire && step_cnt != 2'd0) begin
      cnt_q <= step_cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Queue entries carry no reset; the count alone says which are live.
  always_ff @(posedge clk_i) begin
    if (fire && step_cnt != 2'd0) begin
      res_q <= step_res;
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign out_valid_o     = (cnt_q != 2'd0);
  assign command_o       = res_q[0].command;
  assign column_o        = res_q[0].column;
  assign row_o           = res_q[0].row;
  assign out_char_o      = res_q[0].out_char;
  assign out_attribute_o = res_q[0].out_attribute;
  assign view_baseline_o = res_q[0].view_baseline;
  assign last_o          = res_q[0].last;

  // The last flag sits exactly on the final entry left in the queue.
  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (cnt_q == 2'd1)))
    else $error("last flag does not match the queue fill");

  // A beat only passes a busy queue when it adds no commands.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !room) |-> (step_cnt == 2'd0))
    else $error("result queue overwritten while busy");

  // Cursor and view state stay put unless a beat is processed.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> ($stable(col_q) && $stable(row_q) && $stable(base_q)))
    else $error("cursor state moved without a beat");

  // A beat waiting in the input register is kept until it is processed.
  a_item_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && !fire) |=> (item_valid_q && $stable(item_q)))
    else $error("pending input beat lost");

endmodule

// ----- tb/tb_text_console_cursor_control_unit.sv -----
// Self-checking testbench for the text console cursor and scrollback controller.
`timescale 1ns / 1ps

module tb_text_console_cursor_control_unit;

  import tccc_pkg::*;

  // Sizes the block is built with; the expectations saturate registers to the same bounds.
  localparam int COLS_MAX    = 128;
  localparam int LINES_MAX   = 256;
  // A beat that causes no command can still sit in the pipeline when the last expected
  // command has come out. It has only the input register to pass, so this pause is
  // comfortably long enough before a register write.
  localparam int SETTLE      = 8;
  // Length of the one long stall of the command side, and the limit on cycles without
  // any beat moving on either side before the run is abandoned.
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;

  // The tracker follows the cursor, the view and the registers exactly as the block
  // should, and keeps the commands it still expects in the order they must appear.
  class command_tracker;
    result_t     expected_cmds[$];
    int unsigned mismatches;
    int unsigned width_reg, window_reg, buffer_reg, attr_reg;
    int unsigned cur_col, cur_row, view_top;

    function new();
      width_reg  = LINE_WIDTH_RST;
      window_reg = WINDOW_HEIGHT_RST;
      buffer_reg = BUFFER_HEIGHT_RST;
      attr_reg   = TEXT_ATTR_RST;
      cur_col    = 0;
      cur_row    = 0;
      view_top   = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] data);
      case (idx)
        CFG_LINE_WIDTH:    width_reg  = data[7:0];
        CFG_WINDOW_HEIGHT: window_reg = data;
        CFG_BUFFER_HEIGHT: buffer_reg = data;
        CFG_TEXT_ATTR:     attr_reg   = data[7:0];
        default: ;
      endcase
    endfunction

    // Register values in use, after saturation to what the block can hold.
    function int unsigned columns();
      if (width_reg < 1) return 1;
      if (width_reg > COLS_MAX) return COLS_MAX;
      return width_reg;
    endfunction

    function int unsigned lines();
      if (buffer_reg < 1) return 1;
      if (buffer_reg > LINES_MAX) return LINES_MAX;
      return buffer_reg;
    endfunction

    function int unsigned shown();
      int unsigned b;
      b = lines();
      if (window_reg < 1) return 1;
      if (window_reg > b) return b;
      return window_reg;
    endfunction

    function void push(command_e cmd, int unsigned col, int unsigned row,
                       int unsigned ch, int unsigned attr);
      result_t r;
      r.command       = cmd;
      r.column        = 7'(col);
      r.row           = 8'(row);
      r.out_char      = 8'(ch);
      r.out_attribute = 8'(attr);
      r.view_baseline = 8'(view_top);
      r.last          = 1'b0;
      expected_cmds.push_back(r);
    endfunction

    // Moves down one row, or rolls the buffer when the cursor sits on (or beyond) the
    // last row. The roll reports the view before it is pulled up; the refresh after.
    function void line_feed();
      int unsigned b, w;
      b = lines();
      w = shown();
      if (cur_row < b - 1) begin
        cur_row++;
        if (cur_row == view_top + w) view_top++;
      end else begin
        push(CMD_ROLL, 0, 0, 0, 0);
        if (view_top < b - w && view_top > 0) view_top--;
      end
      view_top &= 'hFF;
      push(CMD_REFRESH, 0, 0, 0, 0);
    endfunction

    function void take_input(logic op, logic [7:0] ch, logic [8:0] req);
      int unsigned before_cnt, width, top, y;
      before_cnt = expected_cmds.size();
      width      = columns();
      if (op == OP_BASELINE) begin
        // A negative request pins the view to the top; otherwise it may not pass the
        // cursor row nor leave the window hanging below the end of the buffer.
        top = lines() - shown();
        if (req[8]) begin
          y = 0;
        end else begin
          y = req[7:0];
          if (y > cur_row) y = cur_row;
          if (y >= top) y = top;
        end
        view_top = y & 'hFF;
        push(CMD_REFRESH, 0, 0, 0, 0);
      end else begin
        case (ch)
          CH_CR: cur_col = 0;
          CH_LF: line_feed();
          CH_VT: begin
            if (cur_col != 0) begin
              cur_col = 0;
              line_feed();
            end
          end
          CH_BS: begin
            if (cur_col > 0) begin
              cur_col--;
            end else if (cur_row > 0) begin
              cur_row--;
              cur_col = width - 1;
            end
          end
          CH_FF: begin
            push(CMD_CLEAR, 0, 0, 0, 0);
            view_top = 0;
            cur_col  = 0;
            cur_row  = 0;
            push(CMD_REFRESH, 0, 0, 0, 0);
          end
          CH_TAB: begin
            cur_col = (cur_col & ~32'(TAB_STEP - 1)) + TAB_STEP;
            if (cur_col > width) cur_col = width;
          end
          default: begin
            // Printable: wrap first when the line is already full.
            if (cur_col >= width) begin
              cur_col = 0;
              line_feed();
            end
            push(CMD_PUT, cur_col, cur_row, ch, attr_reg);
            cur_col++;
          end
        endcase
      end
      if (expected_cmds.size() > before_cnt)
        expected_cmds[expected_cmds.size() - 1].last = 1'b1;
    endfunction

    function void check_command(result_t got);
      result_t want;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: command beat cmd=%0d with none expected", $time, got.command);
        return;
      end
      want = expected_cmds.pop_front();
      if (got.command !== want.command || got.column !== want.column ||
          got.row !== want.row || got.out_char !== want.out_char ||
          got.out_attribute !== want.out_attribute ||
          got.view_baseline !== want.view_baseline || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: command beat differs: expected cmd=%0d col=%0d row=%0d char=%02h attr=%02h base=%0d last=%0d",
                   $time, want.command, want.column, want.row, want.out_char,
                   want.out_attribute, want.view_baseline, want.last);
          $display("%0t: command beat differs: got cmd=%0d col=%0d row=%0d char=%02h attr=%02h base=%0d last=%0d",
                   $time, got.command, got.column, got.row, got.out_char,
                   got.out_attribute, got.view_baseline, got.last);
        end
      end
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction
  endclass

  logic              clk_i                = 1'b0;
  logic              rst_ni               = 1'b0;
  logic              cfg_we_i             = 1'b0;
  logic [1:0]        cfg_index_i          = CFG_LINE_WIDTH;
  logic [8:0]        cfg_data_i           = '0;
  logic              in_valid_i           = 1'b0;
  logic              operation_i          = OP_WRITE;
  logic [7:0]        char_code_i          = '0;
  logic signed [8:0] requested_baseline_i = '0;
  logic              out_ready_i          = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [1:0]        command_o;
  logic [6:0]        column_o;
  logic [7:0]        row_o;
  logic [7:0]        out_char_o;
  logic [7:0]        out_attribute_o;
  logic [7:0]        view_baseline_o;
  logic              last_o;

  command_tracker tracker = new;

  // Shared between the stimulus and the command-side process: idle gaps on or off, and a
  // request for the one long stall of the command side.
  bit gaps_on   = 1'b1;
  bit sink_hold = 1'b0;
  int quiet_cycles = 0;

  text_console_cursor_control_unit #(
    .MAX_COLUMNS (COLS_MAX),
    .MAX_LINES   (LINES_MAX)
  ) u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .operation_i          (operation_i),
    .char_code_i          (char_code_i),
    .requested_baseline_i (requested_baseline_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .command_o            (command_o),
    .column_o             (column_o),
    .row_o                (row_o),
    .out_char_o           (out_char_o),
    .out_attribute_o      (out_attribute_o),
    .view_baseline_o      (view_baseline_o),
    .last_o               (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Idle lengths: mostly none, often short, now and then a long gap.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one input beat and returns at the edge where it is taken. Valid is left high,
  // so a following beat without a gap keeps it high without a dip.
  task automatic offer_beat(logic op, logic [7:0] ch, logic [8:0] req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    operation_i          <= op;
    char_code_i          <= ch;
    requested_baseline_i <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.take_input(op, ch, req);
  endtask

  // Random beat: mostly printable bytes and control codes, with a share of baseline
  // requests and of fully random bytes. Form feed is kept rare as it wipes the state.
  task automatic offer_random_beat();
    int         r;
    logic [7:0] ch;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      offer_beat(OP_BASELINE, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
    end else begin
      if (r < 22)      ch = CH_LF;
      else if (r < 26) ch = CH_CR;
      else if (r < 30) ch = CH_VT;
      else if (r < 35) ch = CH_BS;
      else if (r < 40) ch = CH_TAB;
      else if (r < 42) ch = CH_FF;
      else if (r < 48) ch = 8'($urandom_range(0, 255));
      else if (r < 56) ch = 8'($urandom_range(0, 7));
      else             ch = 8'($urandom_range(14, 255));
      offer_beat(OP_WRITE, ch, 9'($urandom_range(0, 511)));
    end
  endtask

  // Stops offering and waits until every expected command has come out, then lets any
  // beat that causes no command clear the pipeline.
  task automatic drain_commands();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Writes all four registers on consecutive edges; only called with the block idle.
  task automatic program_console(logic [8:0] lw, logic [8:0] wh, logic [8:0] bh,
                                 logic [8:0] attr);
    logic [8:0] vals [4];
    logic [1:0] idx [4];
    vals = '{lw, wh, bh, attr};
    idx  = '{CFG_LINE_WIDTH, CFG_WINDOW_HEIGHT, CFG_BUFFER_HEIGHT, CFG_TEXT_ATTR};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      tracker.write_reg(idx[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int n);
    repeat (n) offer_random_beat();
    drain_commands();
  endtask

  // Command side: ready with random gaps, and once a long stall on request so that the
  // result queue fills and the input side has to back off.
  initial begin : p_sink
    int gap;
    wait (rst_ni);
    forever begin
      if (sink_hold) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold = 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        gap = pick_gap();
        out_ready_i <= 1'b0;
        repeat (gap + 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Every command beat taken is checked against the oldest expectation.
  always @(posedge clk_i) begin : p_monitor
    result_t seen;
    if (out_valid_o && out_ready_i) begin
      seen.command       = command_e'(command_o);
      seen.column        = column_o;
      seen.row           = row_o;
      seen.out_char      = out_char_o;
      seen.out_attribute = out_attribute_o;
      seen.view_baseline = view_baseline_o;
      seen.last          = last_o;
      tracker.check_command(seen);
    end
  end

  // Watchdog: too long without a beat on either side means the block has hung.
  always @(posedge clk_i) begin : p_watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : p_stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, first with the registers as they come out of reset.
    offer_beat(OP_WRITE, 8'h41, 9'd0);        // put at the top left corner
    offer_beat(OP_WRITE, 8'h00, 9'h1FF);      // lowest byte is printable
    offer_beat(OP_WRITE, 8'hFF, 9'd0);        // highest byte is printable
    offer_beat(OP_WRITE, CH_VT, 9'd0);        // vertical tab away from column 0
    offer_beat(OP_WRITE, CH_VT, 9'd0);        // vertical tab at column 0 does nothing
    offer_beat(OP_WRITE, CH_BS, 9'd0);        // backspace from column 0 to the row above
    offer_beat(OP_WRITE, CH_TAB, 9'd0);       // tab saturates at the line width
    offer_beat(OP_WRITE, 8'h7E, 9'd0);        // full line, so the put wraps
    offer_beat(OP_WRITE, CH_CR, 9'd0);
    offer_beat(OP_WRITE, CH_LF, 9'd0);
    offer_beat(OP_BASELINE, 8'hFF, 9'h100);   // most negative request
    offer_beat(OP_BASELINE, 8'h00, 9'h0FF);   // largest request, held to the cursor row
    offer_beat(OP_WRITE, CH_FF, 9'd0);        // clear
    offer_beat(OP_WRITE, CH_BS, 9'd0);        // backspace stays at the top left corner
    offer_beat(OP_BASELINE, 8'h5A, 9'h1FF);   // request of minus one
    drain_commands();

    // A tiny console, so that wraps, view moves and rolls come quickly.
    program_console(9'd4, 9'd2, 9'd3, 9'h03C);
    offer_beat(OP_WRITE, CH_TAB, 9'd0);
    offer_beat(OP_WRITE, CH_TAB, 9'd0);       // already at the width
    offer_beat(OP_WRITE, 8'h61, 9'd0);        // wrap onto the next row
    offer_beat(OP_WRITE, CH_LF, 9'd0);        // cursor leaves the window, view follows
    offer_beat(OP_WRITE, CH_LF, 9'd0);        // last buffer row: roll
    offer_beat(OP_WRITE, 8'h62, 9'd0);
    offer_beat(OP_WRITE, 8'h63, 9'd0);
    offer_beat(OP_WRITE, 8'h64, 9'd0);
    offer_beat(OP_WRITE, 8'h65, 9'd0);        // wrap with roll: three commands
    offer_beat(OP_BASELINE, 8'h00, 9'd2);     // limited by the buffer end
    drain_commands();

    // Registers back at their reset values.
    program_console(9'(LINE_WIDTH_RST), 9'(WINDOW_HEIGHT_RST), 9'(BUFFER_HEIGHT_RST),
                    9'(TEXT_ATTR_RST));
    random_phase(40);

    // Small console. Halfway the command side stalls for a long stretch while the
    // input side keeps offering printable beats without gaps, so the block fills up.
    program_console(9'd7, 9'd3, 9'd5, 9'h0A5);
    repeat (17) offer_random_beat();
    drain_commands();
    sink_hold = 1'b1;
    gaps_on   = 1'b0;
    repeat (16) offer_beat(OP_WRITE, 8'($urandom_range(32, 126)), 9'd0);
    gaps_on   = 1'b1;
    random_phase(17);

    // Largest sizes the block supports.
    program_console(9'd128, 9'd256, 9'd256, 9'h0FF);
    random_phase(30);

    // Smallest sizes, with no idling on either side; stale cursor values from the
    // larger console take the roll path.
    gaps_on = 1'b0;
    program_console(9'd1, 9'd1, 9'd1, 9'h000);
    random_phase(25);
    gaps_on = 1'b1;

    // Out of range values: the width saturates at its maximum, a zero buffer counts as
    // one line and the window is held to it.
    program_console(9'h1FF, 9'h1FF, 9'h000, 9'h1FF);
    random_phase(25);

    // Random register values over the whole of each field.
    repeat (2) begin
      program_console(9'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
                      9'($urandom_range(0, 511)), 9'($urandom_range(0, 255)));
      random_phase(25);
    end

    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
